// File: design/lpmd_pkg.sv
package lpmd_pkg;

  localparam int FIELD_BYTES_DEF = 4;
  localparam int BYTE_W          = 8;
  localparam int WORD_W          = 32;
  localparam int WORD_BYTES      = WORD_W / BYTE_W;
  localparam int IN_TDATA_W      = 8;
  localparam int OUT_TDATA_W     = 72;

  localparam int TAG_LSB = BYTE_W;
  localparam int LEN_LSB = BYTE_W + WORD_W;

endpackage

// File: design/length_prefixed_message_deframer.sv
// Length-prefixed message deframer.
//
// Input channel (in_*): one stream byte per transfer. in_tuser high marks
// the first byte of a new connection: any partial message is dropped and
// the byte is taken as the first header byte.
// A message is a FIELD_BYTES-byte length and a FIELD_BYTES-byte tag, both
// little-endian (only the low 32 bits of each are kept), then the payload.
// Output channel (out_*): one transfer per payload byte, carrying the byte,
// the message tag and length; out_tlast marks the final byte. A zero-length
// message gives a single transfer with out_tuser (empty) and out_tlast set.
// Header bytes give no output.
// A result appears in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle while the receiver does not stall, set by the single output register.
// The input is taken whenever the output register is empty or being drained
// in the same cycle; when the receiver stalls, the result holds and the
// input stalls with it.
// Reset clears the header count, length, tag and payload state; the output
// register comes up empty.
module length_prefixed_message_deframer
  import lpmd_pkg::*;
#(
  parameter int FIELD_BYTES = FIELD_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] new_connection
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] payload_byte, [39:8] msg_tag,
                                             // [71:40] msg_length
  output logic                   out_tuser,  // [0] is_empty
  output logic                   out_tlast   // last_byte
);

  localparam int HDR_BYTES = 2 * FIELD_BYTES;
  localparam int HC_W      = (HDR_BYTES > 2) ? $clog2(HDR_BYTES) : 1;

  logic [HC_W-1:0]   hdr_cnt_r, hdr_cnt_nxt;
  logic [WORD_W-1:0] len_r, len_nxt;
  logic [WORD_W-1:0] tag_r, tag_nxt;
  logic [WORD_W-1:0] left_r, left_nxt;
  logic              in_pay_r, in_pay_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [WORD_W-1:0] out_tag_r, out_tag_nxt;
  logic [WORD_W-1:0] out_len_r, out_len_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic [BYTE_W-1:0] din;
  logic              emit;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign din       = in_tdata[BYTE_W-1:0];

  always_comb begin
    logic [HC_W-1:0]   hc;
    logic [WORD_W-1:0] len_c;
    logic [WORD_W-1:0] tag_c;
    logic [WORD_W-1:0] left_c;
    logic              pay_c;
    int                pos;
    int                nxt;

    hc     = hdr_cnt_r;
    len_c  = len_r;
    tag_c  = tag_r;
    left_c = left_r;
    pay_c  = in_pay_r;
    pos    = 0;
    nxt    = 0;

    hdr_cnt_nxt  = hdr_cnt_r;
    len_nxt      = len_r;
    tag_nxt      = tag_r;
    left_nxt     = left_r;
    in_pay_nxt   = in_pay_r;
    emit         = 1'b0;
    out_byte_nxt = din;
    out_tag_nxt  = tag_r;
    out_len_nxt  = len_r;
    out_empty_nxt = 1'b0;
    out_last_nxt  = 1'b0;

    if (in_tuser) begin
      hc     = '0;
      len_c  = '0;
      tag_c  = '0;
      left_c = '0;
      pay_c  = 1'b0;
    end

    if (pay_c) begin
      emit          = 1'b1;
      out_tag_nxt   = tag_c;
      out_len_nxt   = len_c;
      out_last_nxt  = (left_c == WORD_W'(1));
      left_nxt      = left_c - WORD_W'(1);
      len_nxt       = len_c;
      tag_nxt       = tag_c;
      hdr_cnt_nxt   = hc;
      in_pay_nxt    = 1'b1;
      if (left_c == WORD_W'(1)) begin
        in_pay_nxt  = 1'b0;
        hdr_cnt_nxt = '0;
      end
    end else begin
      if (hc == '0) begin
        len_c = '0;
        tag_c = '0;
      end
      if (int'(hc) < FIELD_BYTES) begin
        pos = int'(hc);
        for (int k = 0; k < WORD_BYTES; k++) begin
          if (pos == k) len_c[k*BYTE_W +: BYTE_W] = len_c[k*BYTE_W +: BYTE_W] | din;
        end
      end else begin
        pos = int'(hc) - FIELD_BYTES;
        for (int k = 0; k < WORD_BYTES; k++) begin
          if (pos == k) tag_c[k*BYTE_W +: BYTE_W] = tag_c[k*BYTE_W +: BYTE_W] | din;
        end
      end
      nxt        = int'(hc) + 1;
      len_nxt    = len_c;
      tag_nxt    = tag_c;
      left_nxt   = left_c;
      in_pay_nxt = 1'b0;
      if (nxt >= HDR_BYTES) begin
        hdr_cnt_nxt = '0;
        if (len_c == '0) begin
          emit          = 1'b1;
          out_byte_nxt  = '0;
          out_tag_nxt   = tag_c;
          out_len_nxt   = '0;
          out_empty_nxt = 1'b1;
          out_last_nxt  = 1'b1;
        end else begin
          in_pay_nxt = 1'b1;
          left_nxt   = len_c;
        end
      end else begin
        hdr_cnt_nxt = HC_W'(nxt);
      end
    end

    out_valid_nxt = out_valid_r && !out_tready;
    if (accept && emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r   <= '0;
      len_r       <= '0;
      tag_r       <= '0;
      left_r      <= '0;
      in_pay_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        hdr_cnt_r <= hdr_cnt_nxt;
        len_r     <= len_nxt;
        tag_r     <= tag_nxt;
        left_r    <= left_nxt;
        in_pay_r  <= in_pay_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte_r  <= out_byte_nxt;
      out_tag_r   <= out_tag_nxt;
      out_len_r   <= out_len_nxt;
      out_empty_r <= out_empty_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_tag_r, out_byte_r};
  assign out_tuser  = out_empty_r;
  assign out_tlast  = out_last_r;

endmodule

// File: design/lpmd_checker.sv
module lpmd_checker
  import lpmd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output transfer changed");

  // no input taken while the output register is full and stalled
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input ready while output stalled");

  // empty message result is a lone last transfer with zero byte and length
  a_empty_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata[7:0] == 8'h00)
      && (out_tdata[71:40] == 32'h0))
    else $error("malformed empty-message transfer");

  // a payload transfer belongs to a message of nonzero length
  a_pay_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata[71:40] != 32'h0))
    else $error("payload transfer with zero length");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind length_prefixed_message_deframer lpmd_checker u_lpmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: sim/deframer_checker.sv
module deframer_checker
  import lpmd_pkg::*;
#(
  parameter int FIELD_BYTES = FIELD_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] new_connection
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] payload_byte, [39:8] msg_tag,
                                             // [71:40] msg_length
  input  logic                   out_tuser,  // [0] is_empty
  input  logic                   out_tlast,  // last_byte
  output int                     mismatches,
  output int                     outstanding,
  output int                     results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BYTE_W-1:0]        data;
    logic signed [WORD_W-1:0] tag;
    logic [WORD_W-1:0]        length;
    logic                     empty;
    logic                     last;
  } msg_byte_t;

  msg_byte_t pending_results[$];

  logic [3:0]        hdr_cnt;
  logic [WORD_W-1:0] len_acc;
  logic [WORD_W-1:0] tag_acc;
  logic [WORD_W-1:0] remaining;
  logic              in_body;

  initial begin
    mismatches   = 0;
    results_seen = 0;
    outstanding  = 0;
  end

  function automatic void clear_framing();
    hdr_cnt   = '0;
    len_acc   = '0;
    tag_acc   = '0;
    remaining = '0;
    in_body   = 1'b0;
  endfunction

  function automatic void deframe_byte(input logic [BYTE_W-1:0] b, input logic nc);
    msg_byte_t r;
    int        pos;
    int        nxt;
    if (nc) clear_framing();
    if (in_body) begin
      r = '{data: b, tag: tag_acc, length: len_acc, empty: 1'b0, last: remaining == 1};
      pending_results.push_back(r);
      remaining = remaining - 1;
      if (remaining == 0) begin
        in_body = 1'b0;
        hdr_cnt = '0;
      end
      return;
    end
    if (hdr_cnt == 0) begin
      len_acc = '0;
      tag_acc = '0;
    end
    if (hdr_cnt < FIELD_BYTES) begin
      pos = int'(hdr_cnt);
      if (pos < WORD_BYTES) len_acc = len_acc | (WORD_W'(b) << (8 * pos));
    end else begin
      pos = int'(hdr_cnt) - FIELD_BYTES;
      if (pos < WORD_BYTES) tag_acc = tag_acc | (WORD_W'(b) << (8 * pos));
    end
    nxt = int'(hdr_cnt) + 1;
    if (nxt >= 2 * FIELD_BYTES) begin
      hdr_cnt = '0;
      if (len_acc == 0) begin
        r = '{data: '0, tag: tag_acc, length: '0, empty: 1'b1, last: 1'b1};
        pending_results.push_back(r);
      end else begin
        in_body   = 1'b1;
        remaining = len_acc;
      end
    end else begin
      hdr_cnt = nxt[3:0];
    end
  endfunction

  task automatic note_mismatch(input string what, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    msg_byte_t want;
    if (!rst_n) begin
      clear_framing();
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected transfer, byte", WORD_W'(out_tdata[BYTE_W-1:0]), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[BYTE_W-1:0] !== want.data)
            note_mismatch("payload_byte", WORD_W'(out_tdata[BYTE_W-1:0]),
                          WORD_W'(want.data));
          if (out_tdata[TAG_LSB +: WORD_W] !== want.tag)
            note_mismatch("msg_tag", out_tdata[TAG_LSB +: WORD_W], want.tag);
          if (out_tdata[LEN_LSB +: WORD_W] !== want.length)
            note_mismatch("msg_length", out_tdata[LEN_LSB +: WORD_W], want.length);
          if (out_tuser !== want.empty)
            note_mismatch("is_empty", WORD_W'(out_tuser), WORD_W'(want.empty));
          if (out_tlast !== want.last)
            note_mismatch("last_byte", WORD_W'(out_tlast), WORD_W'(want.last));
        end
      end
      if (in_tvalid && in_tready) deframe_byte(in_tdata[BYTE_W-1:0], in_tuser);
      outstanding <= pending_results.size();
    end
  end

endmodule

// File: sim/length_prefixed_message_deframer_tb.sv
module length_prefixed_message_deframer_tb;
  import lpmd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB          = FIELD_BYTES_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int N_RANDOM    = 550;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  int mismatches;
  int outstanding;
  int results_seen;

  int n_items    = 0;
  int n_msgs     = 0;
  int n_broken   = 0;
  bit tx_gaps    = 1'b1;
  bit rx_gaps    = 1'b1;
  bit hold_req   = 1'b0;
  int hold_left  = 0;
  int idle_count = 0;

  always #10 clk = ~clk;

  length_prefixed_message_deframer #(.FIELD_BYTES(FB)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  deframer_checker #(.FIELD_BYTES(FB)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(rx_gaps && $urandom_range(0, 99) < 7);
      end
    end
  end

  initial begin
    while (idle_count < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_count = 0;
      else
        idle_count++;
    end
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("length_prefixed_message_deframer regression: fail");
    $finish;
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic nc);
    if (tx_gaps && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= nc;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
  endtask

  task automatic send_msg(input logic [WORD_W-1:0] len, input logic [WORD_W-1:0] tag,
                          input logic nc_first, input int body);
    logic [WORD_W-1:0] fld;
    logic [BYTE_W-1:0] b;
    int                pos;
    for (int i = 0; i < 2 * FB; i++) begin
      fld = (i < FB) ? len : tag;
      pos = i % FB;
      b   = (pos < WORD_BYTES) ? fld[8 * pos +: 8] : BYTE_W'($urandom);
      push_byte(b, (i == 0) ? nc_first : 1'b0);
    end
    for (int i = 0; i < body; i++) push_byte(BYTE_W'($urandom), 1'b0);
  endtask

  initial begin
    int          sel;
    int unsigned len;
    bit          resync;
    bit          hold_used;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // zero-length message with the most negative tag
    send_msg(32'h0, 32'h8000_0000, 1'b1, 0);
    // one-byte message, largest tag, all-ones payload
    send_msg(32'h1, 32'h7fff_ffff, 1'b0, 0);
    push_byte(8'hff, 1'b0);
    // largest length, cut short after one zero byte
    send_msg(32'hffff_ffff, 32'hffff_ffff, 1'b0, 0);
    push_byte(8'h00, 1'b0);
    n_msgs   += 2;
    n_broken += 1;
    resync    = 1'b1;
    hold_used = 1'b0;

    while (n_items < N_RANDOM) begin
      tx_gaps = !(n_items > 150 && n_items < 260);
      rx_gaps = tx_gaps;
      sel = $urandom_range(0, 99);
      if (!hold_used && n_items > 300) begin
        hold_used = 1'b1;
        hold_req  = 1'b1;
        send_msg(40, $urandom, resync, 40);
        resync = 1'b0;
        n_msgs++;
      end else if (sel < 80) begin
        if ($urandom_range(0, 9) == 0) len = 0;
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(20, 48);
        else len = $urandom_range(1, 12);
        send_msg(len, $urandom, resync | ($urandom_range(0, 7) == 0), len);
        resync = 1'b0;
        n_msgs++;
      end else if (sel < 90) begin
        len = $urandom | 32'h100;
        send_msg(len, $urandom, resync | ($urandom_range(0, 1) == 1),
                 $urandom_range(0, 5));
        resync = 1'b1;
        n_broken++;
      end else begin
        repeat ($urandom_range(1, 7))
          push_byte(BYTE_W'($urandom), $urandom_range(0, 3) == 0);
        resync = 1'b1;
        n_broken++;
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes: %0d whole messages, %0d cut-short or noise runs",
             n_items, n_msgs, n_broken);
    $display("checked %0d deframed transfers, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("length_prefixed_message_deframer regression: pass");
    else
      $display("length_prefixed_message_deframer regression: fail");
    $finish;
  end

endmodule
